@@ hw/rtl/adrc_pkg.sv @@
// Package for the audio dynamic range compressor: widths, register indexes,
// gain modes and the constant table of 2^(2^-k) roots used by the dB-to-gain step.
// No dependencies; every RTL file of the block uses it by scoped names.
package adrc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

    // Gain computer modes.
    localparam logic [1:0] MODE_SOFT   = 2'd0;
    localparam logic [1:0] MODE_HARD   = 2'd1;
    localparam logic [1:0] MODE_LIMIT  = 2'd2;
    localparam logic [1:0] MODE_BYPASS = 2'd3;

    // Fixed-point conversion factors.
    localparam logic [31:0] DB_PER_OCTAVE_Q16   = 32'd394566;
    localparam logic [31:0] OCTAVE_PER_DBQ8_Q16 = 32'd2786635;

    // Shared multiplier: 33 x 33 signed, so any 32-bit unsigned value fits.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Iterative divider widths; the quotient is known to stay below 2^16.
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 32;
    localparam int DIV_Q_W = 16;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [31:0] root_tab_t [16];

    // Entry k holds 2^(2^(k-16)) in Q30, built by repeated floored square roots.
    function automatic root_tab_t make_roots();
        root_tab_t tab;
        longint unsigned r;
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        int k;
        int i;
        r = 64'd2 << 30;
        for (k = 15; k >= 0; k--)
        begin
            v   = r << 30;
            res = 64'd0;
            b   = 64'd1 << 62;
            for (i = 0; i < 32; i++)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            r      = res;
            tab[k] = r[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOTS = make_roots();

endpackage

@@ hw/rtl/adrc_mul.sv @@
// Shared signed multiplier of the compressor with a registered product.
// Depends on adrc_pkg for operand and product types.
module adrc_mul
(
    input  logic             clk,
    input  adrc_pkg::mul_op_t op_a,
    input  adrc_pkg::mul_op_t op_b,
    output adrc_pkg::prod_t   prod
);

    adrc_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/adrc_div.sv @@
// Restoring divider of the compressor, one quotient bit per cycle.
// Depends on adrc_pkg for widths; the caller guarantees a quotient below 2^16.
module adrc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [adrc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [adrc_pkg::DIV_D_W-1:0]  divisor,
    output logic                          done,
    output logic [adrc_pkg::DIV_Q_W-1:0]  quotient
);

    logic [adrc_pkg::DIV_N_W-1:0] rem_reg;
    logic [adrc_pkg::DIV_N_W-1:0] dsh_reg;
    logic [adrc_pkg::DIV_Q_W-1:0] q_reg;
    logic [3:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= dividend;
                dsh_reg  <= adrc_pkg::DIV_N_W'({divisor, {(adrc_pkg::DIV_Q_W-1){1'b0}}});
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[adrc_pkg::DIV_Q_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/audio_dynamic_range_compressor.sv @@
// Top level of the audio dynamic range compressor: configuration registers,
// sequencer and datapath. Depends on adrc_pkg, adrc_mul and adrc_div.
//
// Feedforward compressor with a peak envelope follower. Each input transaction
// carries one signed sample. The sample magnitude (at least one LSB) updates the
// envelope with the attack coefficient when it rises above it and with the release
// coefficient otherwise. The envelope is converted to dB, a gain computer (soft
// knee, hard knee, limiter or bypass) yields a gain reduction, makeup gain is
// added, the sum is turned into a linear gain, and the compressed sample is mixed
// with the dry one by the wet fraction and saturated. Each input transaction
// gives exactly one output transaction with the sample and the gain reduction.
// All arithmetic runs through one registered 33 x 33 multiplier and one
// bit-serial divider under a small sequencer, so the block takes one sample at a
// time: in_stall is high from acceptance until the result is loaded into the
// output register. The time a sample takes is set by the sixteen squarings of
// the log2 step and the up to sixteen products of the exponent step, each a
// pass through the shared multiplier, plus a divider run in the knee or
// above-threshold region. Bypass mode goes straight to the output state and
// leaves the envelope untouched. The output register lets the next sample be
// accepted while a finished result still waits. Configuration is written through
// a plain write port and takes effect for the next sample; write it only while
// the block is idle.
module audio_dynamic_range_compressor
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [adrc_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [adrc_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic signed [14:0]                     gain_reduction_db
);

    localparam int SB = adrc_pkg::SAMPLE_BITS;

    // Sequencer states.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ENV1    = 5'd1;
    localparam logic [4:0] S_ENV2    = 5'd2;
    localparam logic [4:0] S_ENV3    = 5'd3;
    localparam logic [4:0] S_NORM    = 5'd4;
    localparam logic [4:0] S_LOG_MUL = 5'd5;
    localparam logic [4:0] S_LOG_ACC = 5'd6;
    localparam logic [4:0] S_ATT_MUL = 5'd7;
    localparam logic [4:0] S_ATT     = 5'd8;
    localparam logic [4:0] S_GC      = 5'd9;
    localparam logic [4:0] S_SK1     = 5'd10;
    localparam logic [4:0] S_SK2     = 5'd11;
    localparam logic [4:0] S_SK3     = 5'd12;
    localparam logic [4:0] S_HK1     = 5'd13;
    localparam logic [4:0] S_DIV     = 5'd14;
    localparam logic [4:0] S_DB_MUL  = 5'd15;
    localparam logic [4:0] S_DB      = 5'd16;
    localparam logic [4:0] S_EXP_CHK = 5'd17;
    localparam logic [4:0] S_EXP_ACC = 5'd18;
    localparam logic [4:0] S_GAIN    = 5'd19;
    localparam logic [4:0] S_CMP     = 5'd20;
    localparam logic [4:0] S_MIX1    = 5'd21;
    localparam logic [4:0] S_MIX2    = 5'd22;
    localparam logic [4:0] S_OUT     = 5'd23;

    // Configuration registers.
    logic signed [14:0] thr_reg;
    logic [12:0]        ratio_reg;
    logic [12:0]        knee_reg;
    logic [12:0]        makeup_reg;
    logic [16:0]        wet_reg;
    logic [23:0]        attack_reg;
    logic [23:0]        release_reg;
    logic [1:0]         mode_reg;

    // Sequencer and datapath registers.
    logic [4:0]             state_reg;
    logic [4:0]             state_next;
    logic signed [SB-1:0]   x_reg;
    logic [31:0]            env_reg;
    logic [23:0]            c_reg;
    adrc_pkg::prod_t        acc_reg;
    logic [31:0]            m_reg;
    logic [15:0]            frac_reg;
    logic [4:0]             lz_reg;
    logic [3:0]             cnt_reg;
    logic signed [16:0]     xdb_reg;
    logic [14:0]            d_reg;
    logic signed [14:0]     gr_reg;
    logic signed [7:0]      ip_reg;
    logic [15:0]            f_reg;
    logic signed [32:0]     comp_reg;
    logic signed [SB-1:0]   y_reg;
    logic                   out_valid_reg;
    logic signed [SB-1:0]   out_sample_reg;
    logic signed [14:0]     out_gr_reg;

    // Shared units.
    adrc_pkg::mul_op_t                 mul_a;
    adrc_pkg::mul_op_t                 mul_b;
    adrc_pkg::prod_t                   prod;
    logic                              div_start;
    logic [adrc_pkg::DIV_N_W-1:0]      div_dividend;
    logic [adrc_pkg::DIV_D_W-1:0]      div_divisor;
    logic                              div_done;
    logic [adrc_pkg::DIV_Q_W-1:0]      div_q;

    adrc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    adrc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Derived configuration values.
    logic [12:0] r_eff;
    logic [16:0] w_eff;
    logic [16:0] dry_w;

    assign r_eff = (ratio_reg < 13'd256) ? 13'd256 : ratio_reg;
    assign w_eff = (wet_reg > 17'd65536) ? 17'd65536 : wet_reg;
    assign dry_w = 17'd65536 - w_eff;

    // Detector: magnitude floored at one LSB, aligned to Q1.31.
    logic [SB-1:0] x_abs;
    logic [SB-1:0] mag;
    logic [31:0]   det;
    logic [23:0]   c_sel;
    logic [24:0]   c_comp;

    assign x_abs  = x_reg[SB-1] ? SB'(-x_reg) : SB'(x_reg);
    assign mag    = (x_abs == '0) ? SB'(1) : x_abs;
    assign det    = 32'(mag) << (32 - SB);
    assign c_sel  = (det > env_reg) ? attack_reg : release_reg;
    assign c_comp = 25'h1000000 - 25'(c_reg);

    adrc_pkg::prod_t env_sum;
    logic [31:0]     env_new;

    assign env_sum = acc_reg + prod + adrc_pkg::prod_t'(64'h800000);
    assign env_new = env_sum[55:24];

    // Normalization: five shift steps of 16, 8, 4, 2 and 1 bits.
    logic [5:0]  norm_amt;
    logic        norm_zero;
    logic [31:0] norm_m;

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0:    norm_amt = 6'd16;
            3'd1:    norm_amt = 6'd8;
            3'd2:    norm_amt = 6'd4;
            3'd3:    norm_amt = 6'd2;
            default: norm_amt = 6'd1;
        endcase
    end

    assign norm_zero = ((m_reg >> (6'd32 - norm_amt)) == 32'd0);
    assign norm_m    = norm_zero ? (m_reg << norm_amt) : m_reg;

    // Log2 squaring result.
    logic [31:0] sq;
    assign sq = prod[61:30];

    logic [20:0] neg_oct;
    assign neg_oct = {lz_reg, 16'd0} - {5'd0, frac_reg};

    adrc_pkg::prod_t att_sum;
    assign att_sum = prod + adrc_pkg::prod_t'(64'h800000);

    // Gain computer comparisons in doubled Q8 units.
    logic signed [19:0] x2;
    logic signed [19:0] t2;
    logic signed [19:0] w20;
    logic signed [19:0] knee_lo;
    logic signed [19:0] knee_hi;
    logic signed [17:0] x_minus_t;
    logic signed [19:0] d_full;

    assign x2        = 20'(xdb_reg) <<< 1;
    assign t2        = 20'(thr_reg) <<< 1;
    assign w20       = $signed(20'(knee_reg));
    assign knee_lo   = t2 - w20;
    assign knee_hi   = t2 + w20;
    assign x_minus_t = 18'(xdb_reg) - 18'(thr_reg);
    assign d_full    = x2 - t2 + w20;

    // Gain reduction candidate and its clamp to -16384..0.
    logic signed [17:0] gr_cand;
    logic signed [14:0] gr_clamped;

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            gr_cand = -$signed({2'b00, div_q});
        end
        else if (x_minus_t > 18'sd0)
        begin
            gr_cand = -x_minus_t;
        end
        else
        begin
            gr_cand = 18'sd0;
        end
    end

    always_comb
    begin
        priority if (gr_cand < -18'sd16384)
        begin
            gr_clamped = -15'sd16384;
        end
        else if (gr_cand > 18'sd0)
        begin
            gr_clamped = 15'sd0;
        end
        else
        begin
            gr_clamped = gr_cand[14:0];
        end
    end

    logic signed [15:0] db_total;
    assign db_total = 16'(gr_reg) + $signed({3'b000, makeup_reg});

    adrc_pkg::prod_t exp_sum;
    assign exp_sum = prod + adrc_pkg::prod_t'(64'h20000000);

    // Linear gain in Q24 from mantissa and octave count.
    logic signed [7:0] ip_c;
    logic [5:0]        rshift;
    logic [37:0]       m_up;
    logic [31:0]       gain_lin;

    always_comb
    begin
        priority if (ip_reg > 8'sd6)
        begin
            ip_c = 8'sd6;
        end
        else if (ip_reg < -8'sd40)
        begin
            ip_c = -8'sd40;
        end
        else
        begin
            ip_c = ip_reg;
        end
    end

    assign rshift = 6'(8'sd6 - ip_c);
    assign m_up   = 38'(m_reg) << ip_c[2:0];

    always_comb
    begin
        if (ip_c >= 8'sd0)
        begin
            gain_lin = 32'(m_up >> 6);
        end
        else
        begin
            gain_lin = m_reg >> rshift;
        end
    end

    adrc_pkg::prod_t cmp_sum;
    adrc_pkg::prod_t mix_sum;
    adrc_pkg::prod_t mix_y;
    logic signed [SB-1:0] y_sat;

    assign cmp_sum = prod + adrc_pkg::prod_t'(64'h800000);
    assign mix_sum = acc_reg + prod + adrc_pkg::prod_t'(64'h8000);
    assign mix_y   = mix_sum >>> 16;

    always_comb
    begin
        priority if (mix_y > adrc_pkg::prod_t'({1'b0, {(SB-1){1'b1}}}))
        begin
            y_sat = {1'b0, {(SB-1){1'b1}}};
        end
        else if (mix_y < -adrc_pkg::prod_t'({1'b1, {(SB-1){1'b0}}}))
        begin
            y_sat = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            y_sat = mix_y[SB-1:0];
        end
    end

    // Multiplier operand selection; the product is read one state later.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ENV1:
            begin
                mul_a = $signed(33'(c_sel));
                mul_b = $signed(33'(env_reg));
            end
            S_ENV2:
            begin
                mul_a = $signed(33'(c_comp));
                mul_b = $signed(33'(det));
            end
            S_LOG_MUL:
            begin
                mul_a = $signed(33'(m_reg));
                mul_b = $signed(33'(m_reg));
            end
            S_ATT_MUL:
            begin
                mul_a = $signed(33'(neg_oct));
                mul_b = $signed(33'(adrc_pkg::DB_PER_OCTAVE_Q16));
            end
            S_GC:
            begin
                if (mode_reg == adrc_pkg::MODE_SOFT && x2 < knee_hi)
                begin
                    mul_a = 33'(d_full);
                    mul_b = 33'(d_full);
                end
                else
                begin
                    mul_a = 33'(x_minus_t);
                    mul_b = $signed(33'(r_eff - 13'd256));
                end
            end
            S_SK1:
            begin
                mul_a = $signed(33'(prod[31:0]));
                mul_b = $signed(33'(r_eff - 13'd256));
            end
            S_SK2:
            begin
                mul_a = $signed(33'(r_eff));
                mul_b = $signed(33'(knee_reg));
            end
            S_DB_MUL:
            begin
                mul_a = 33'(db_total);
                mul_b = $signed(33'(adrc_pkg::OCTAVE_PER_DBQ8_Q16));
            end
            S_EXP_CHK:
            begin
                mul_a = $signed(33'(m_reg));
                mul_b = $signed(33'(adrc_pkg::ROOTS[cnt_reg]));
            end
            S_GAIN:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed(33'(gain_lin));
            end
            S_CMP:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed(33'(dry_w));
            end
            S_MIX1:
            begin
                mul_a = comp_reg;
                mul_b = $signed(33'(w_eff));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider launch: soft knee uses 8*R*W with half of it as rounding,
    // the line above the knee divides by R with R/2 as rounding.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        if (state_reg == S_SK3)
        begin
            div_start    = 1'b1;
            div_dividend = acc_reg[47:0] + (prod[47:0] << 2);
            div_divisor  = prod[31:0] << 3;
        end
        else if (state_reg == S_HK1)
        begin
            div_start    = 1'b1;
            div_dividend = prod[47:0] + 48'(r_eff >> 1);
            div_divisor  = 32'(r_eff);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode_reg == adrc_pkg::MODE_BYPASS) ? S_OUT : S_ENV1;
                end
            end
            S_ENV1:    state_next = S_ENV2;
            S_ENV2:    state_next = S_ENV3;
            S_ENV3:    state_next = S_NORM;
            S_NORM:    state_next = (cnt_reg == 4'd4) ? S_LOG_MUL : S_NORM;
            S_LOG_MUL: state_next = S_LOG_ACC;
            S_LOG_ACC: state_next = (cnt_reg == 4'd15) ? S_ATT_MUL : S_LOG_MUL;
            S_ATT_MUL: state_next = S_ATT;
            S_ATT:     state_next = S_GC;
            S_GC:
            begin
                priority if (x2 <= knee_lo)
                begin
                    state_next = S_DB_MUL;
                end
                else if (mode_reg == adrc_pkg::MODE_LIMIT)
                begin
                    state_next = S_DB_MUL;
                end
                else if (mode_reg == adrc_pkg::MODE_SOFT && x2 < knee_hi)
                begin
                    state_next = S_SK1;
                end
                else if (x_minus_t <= 18'sd0)
                begin
                    state_next = S_DB_MUL;
                end
                else
                begin
                    state_next = S_HK1;
                end
            end
            S_SK1:     state_next = S_SK2;
            S_SK2:     state_next = S_SK3;
            S_SK3:     state_next = S_DIV;
            S_HK1:     state_next = S_DIV;
            S_DIV:     state_next = div_done ? S_DB_MUL : S_DIV;
            S_DB_MUL:  state_next = S_DB;
            S_DB:      state_next = S_EXP_CHK;
            S_EXP_CHK:
            begin
                if (f_reg[cnt_reg])
                begin
                    state_next = S_EXP_ACC;
                end
                else if (cnt_reg == 4'd0)
                begin
                    state_next = S_GAIN;
                end
            end
            S_EXP_ACC: state_next = (cnt_reg == 4'd0) ? S_GAIN : S_EXP_CHK;
            S_GAIN:    state_next = S_CMP;
            S_CMP:     state_next = S_MIX1;
            S_MIX1:    state_next = S_MIX2;
            S_MIX2:    state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and the envelope.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            env_reg       <= '0;
            thr_reg       <= 15'sd0;
            ratio_reg     <= 13'd1024;
            knee_reg      <= 13'd1536;
            makeup_reg    <= 13'd0;
            wet_reg       <= 17'd65536;
            attack_reg    <= 24'd16434000;
            release_reg   <= 24'd16774000;
            mode_reg      <= adrc_pkg::MODE_SOFT;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    adrc_pkg::REG_THRESHOLD: thr_reg     <= $signed(cfg_data[14:0]);
                    adrc_pkg::REG_RATIO:     ratio_reg   <= cfg_data[12:0];
                    adrc_pkg::REG_KNEE:      knee_reg    <= cfg_data[12:0];
                    adrc_pkg::REG_MAKEUP:    makeup_reg  <= cfg_data[12:0];
                    adrc_pkg::REG_WET:       wet_reg     <= cfg_data[16:0];
                    adrc_pkg::REG_ATTACK:    attack_reg  <= cfg_data[23:0];
                    adrc_pkg::REG_RELEASE:   release_reg <= cfg_data[23:0];
                    adrc_pkg::REG_MODE:      mode_reg    <= cfg_data[1:0];
                    default:                 mode_reg    <= mode_reg;
                endcase
            end

            if (state_reg == S_ENV3)
            begin
                env_reg <= env_new;
            end

            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_reg  <= sample_in;
                    y_reg  <= sample_in;
                    gr_reg <= 15'sd0;
                end
            end
            S_ENV1:
            begin
                c_reg <= c_sel;
            end
            S_ENV2:
            begin
                acc_reg <= prod;
            end
            S_ENV3:
            begin
                // Log of a zero envelope is taken as log of one LSB.
                m_reg   <= (env_new == 32'd0) ? 32'd1 : env_new;
                lz_reg  <= '0;
                cnt_reg <= '0;
            end
            S_NORM:
            begin
                lz_reg <= lz_reg + (norm_zero ? norm_amt[4:0] : 5'd0);
                if (cnt_reg == 4'd4)
                begin
                    m_reg    <= norm_m >> 1;
                    cnt_reg  <= '0;
                    frac_reg <= '0;
                end
                else
                begin
                    m_reg   <= norm_m;
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
            S_LOG_ACC:
            begin
                frac_reg <= {frac_reg[14:0], sq[31]};
                m_reg    <= sq[31] ? {1'b0, sq[31:1]} : sq;
                cnt_reg  <= cnt_reg + 4'd1;
            end
            S_ATT:
            begin
                xdb_reg <= -$signed({1'b0, att_sum[39:24]});
            end
            S_GC:
            begin
                d_reg <= d_full[14:0];
                if (x2 <= knee_lo)
                begin
                    gr_reg <= 15'sd0;
                end
                else
                begin
                    gr_reg <= gr_clamped;
                end
            end
            S_SK2:
            begin
                acc_reg <= prod;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    gr_reg <= gr_clamped;
                end
            end
            S_DB:
            begin
                ip_reg  <= $signed(prod[39:32]);
                f_reg   <= prod[31:16];
                m_reg   <= 32'h40000000;
                cnt_reg <= 4'd15;
            end
            S_EXP_CHK:
            begin
                if (!f_reg[cnt_reg] && cnt_reg != 4'd0)
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
            S_EXP_ACC:
            begin
                m_reg <= exp_sum[61:30];
                if (cnt_reg != 4'd0)
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
            S_CMP:
            begin
                comp_reg <= cmp_sum[56:24];
            end
            S_MIX1:
            begin
                acc_reg <= prod;
            end
            S_MIX2:
            begin
                y_reg <= y_sat;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_sample_reg <= y_reg;
                    out_gr_reg     <= gr_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign sample_out        = out_sample_reg;
    assign gain_reduction_db = out_gr_reg;

endmodule

@@ tb/tb_audio_dynamic_range_compressor.sv @@
// Self-checking testbench for the audio dynamic range compressor.
// Depends on adrc_pkg and on the audio_dynamic_range_compressor RTL.
// It predicts every result in SystemVerilog and checks each output transaction.
`timescale 1ns / 100ps

module tb_audio_dynamic_range_compressor;

    import adrc_pkg::*;

    localparam int  RUN_LIMIT   = 3000000;
    localparam int  TAIL_CYCLES = 200;
    localparam int  SETTLE      = 8;
    localparam int  SB          = SAMPLE_BITS;

    typedef struct packed
    {
        logic signed [SB-1:0] sample;
        logic signed [14:0]   gr_db;
    } comp_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SB-1:0]    sample_in;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SB-1:0]    sample_out;
    logic signed [14:0]      gain_reduction_db;

    audio_dynamic_range_compressor dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_in         (sample_in),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_out        (sample_out),
        .gain_reduction_db (gain_reduction_db)
    );

    // Mirror of the configuration registers and of the envelope follower.
    logic [14:0] thr_q8;
    logic [12:0] ratio_q8;
    logic [12:0] knee_q8;
    logic [12:0] makeup_q8;
    logic [16:0] wet_q16;
    logic [23:0] attack_q24;
    logic [23:0] release_q24;
    logic [1:0]  mode_sel;
    logic [31:0] env_level;

    comp_result_t expected_results[$];
    int           mismatches;
    int           failures;
    int           cycle_count;
    int           hold_cycles;
    bit           offering;
    int           stall_style;
    int           loud_level;

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor. It follows the block's fixed-point arithmetic step by step:
    // peak envelope, log2 by repeated squaring, gain computer, and the
    // exponent built from square roots of two.
    // ------------------------------------------------------------------
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        int i;
        res = 0;
        b   = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Envelope (full scale at 2^31) to level in dB, Q8, never positive.
    function automatic longint envelope_to_db(logic [31:0] env);
        longint unsigned e;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned neg;
        int msb;
        int i;
        e    = (env == 0) ? 64'd1 : 64'(env);
        msb  = 0;
        frac = 0;
        while (msb < 31 && (e >> (msb + 1)) != 0)
            msb++;
        m = (msb >= 30) ? (e >> (msb - 30)) : (e << (30 - msb));
        for (i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 2 * (64'd1 << 30))
            begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        neg = longint'(31 - msb) * 65536 - frac;
        return -longint'((neg * 394566 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic longint knee_curve(longint x);
        longint t;
        longint w;
        longint r;
        longint d;
        longint num;
        longint den;
        t = longint'($signed(thr_q8));
        w = longint'(knee_q8);
        r = (ratio_q8 < 256) ? 256 : longint'(ratio_q8);
        if (2 * x <= 2 * t - w)
            return 0;
        if (mode_sel == MODE_LIMIT)
            return (x > t) ? t - x : 0;
        if (mode_sel == MODE_SOFT && 2 * x < 2 * t + w)
        begin
            d   = 2 * x - 2 * t + w;
            num = (r - 256) * d * d;
            den = 8 * r * w;
            return -((num + den / 2) / den);
        end
        if (x <= t)
            return 0;
        num = (x - t) * (r - 256);
        return -((num + r / 2) / r);
    endfunction

    // dB in Q8 to a linear gain in Q24.
    function automatic longint db_gain_q24(longint db);
        longint e;
        longint ip;
        longint unsigned f;
        longint unsigned m;
        longint unsigned r;
        int k;
        e  = (db * 2786635) >>> 16;
        ip = e >>> 16;
        f  = e - ip * 65536;
        m  = 64'd1 << 30;
        r  = 64'd2 << 30;
        for (k = 15; k >= 0; k--)
        begin
            r = floor_sqrt(r << 30);
            if (f[k])
                m = (m * r + (64'd1 << 29)) >> 30;
        end
        if (ip > 6)
            ip = 6;
        if (ip < -40)
            ip = -40;
        if (ip >= 0)
            return longint'((m << ip) >> 6);
        return longint'(m >> (6 - ip));
    endfunction

    function automatic comp_result_t compress_sample(logic signed [SB-1:0] smp);
        comp_result_t    res;
        longint          x;
        longint          gr;
        longint          g;
        longint          comp;
        longint          y;
        longint          w;
        longint unsigned mag;
        longint unsigned det;
        longint unsigned c;
        x = longint'(smp);
        if (mode_sel == MODE_BYPASS)
        begin
            res.sample = smp;
            res.gr_db  = '0;
            return res;
        end
        mag = (x < 0) ? -x : x;
        if (mag == 0)
            mag = 1;
        det = mag << (32 - SB);
        c   = (det > env_level) ? attack_q24 : release_q24;
        env_level = 32'((c * env_level + ((64'd1 << 24) - c) * det + (64'd1 << 23)) >> 24);
        gr = knee_curve(envelope_to_db(env_level));
        if (gr < -16384)
            gr = -16384;
        if (gr > 0)
            gr = 0;
        g    = db_gain_q24(gr + longint'(makeup_q8));
        comp = (x * g + (64'sd1 <<< 23)) >>> 24;
        w    = (wet_q16 > 65536) ? 65536 : longint'(wet_q16);
        y    = (x * (65536 - w) + comp * w + 32768) >>> 16;
        if (y > (2 ** (SB - 1)) - 1)
            y = (2 ** (SB - 1)) - 1;
        if (y < -(2 ** (SB - 1)))
            y = -(2 ** (SB - 1));
        res.sample = y[SB-1:0];
        res.gr_db  = gr[14:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stalls on its own changing pattern, and holds off for a
    // long stretch whenever hold_cycles is loaded by a test.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style <= 0;
        end
        else
        begin
            if (cycle_count % 97 == 0)
                stall_style <= $urandom_range(0, 3);
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else
            begin
                case (stall_style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= cycle_count[0];
                endcase
            end
        end
    end

    // Checker: every output transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        comp_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result: sample %0d gr %0d",
                             sample_out, gain_reduction_db);
                mismatches++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (sample_out !== exp_res.sample || gain_reduction_db !== exp_res.gr_db)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("mismatch: sample exp %0d got %0d, gr exp %0d got %0d",
                                 exp_res.sample, sample_out, exp_res.gr_db,
                                 gain_reduction_db);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one sample and returns at the edge where the transaction is taken.
    task automatic send_sample(input logic signed [SB-1:0] smp);
        in_valid  <= 1'b1;
        sample_in <= smp;
        offering  = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(compress_sample(smp));
    endtask

    // Random gap after a transaction; some bursts run with no gaps at all.
    task automatic sender_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Stops offering and waits for every predicted result, then lets the
    // block settle so that it is idle for a register write.
    task automatic drain;
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leaves cfg_wr_en high; write_done lowers it once a group of writes ends.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_THRESHOLD: thr_q8      = val[14:0];
            REG_RATIO:     ratio_q8    = val[12:0];
            REG_KNEE:      knee_q8     = val[12:0];
            REG_MAKEUP:    makeup_q8   = val[12:0];
            REG_WET:       wet_q16     = val[16:0];
            REG_ATTACK:    attack_q24  = val[23:0];
            REG_RELEASE:   release_q24 = val[23:0];
            default:       mode_sel    = val[1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_done;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Random value for one register: its ends, all ones, anything in width or anything between its ends.
    function automatic int unsigned pick_reg(input int unsigned lo, input int unsigned hi,
                                             input int unsigned all_ones);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            2:       return all_ones;
            3:       return $urandom & all_ones;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Samples follow a loudness that changes now and then, so the envelope
    // sees both attack and release; a few are full-range noise or extremes.
    function automatic logic signed [SB-1:0] pick_sample;
        int unsigned r;
        if ($urandom_range(0, 49) == 0)
            loud_level = $urandom_range(0, SB - 1);
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return $urandom_range(0, 1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        return SB'($signed($urandom_range(0, (2 << loud_level) - 1)) - (1 << loud_level));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset settings with the extreme samples, quiet ones and two mid-level ones.
    task automatic test_reset_defaults;
        logic signed [SB-1:0] edge_vals[8];
        int i;
        edge_vals = '{ {1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, '0, 1, -1,
                       {1'b0, {(SB-1){1'b1}}}, 24'sh123456, -24'sh2aaaaa };
        for (i = 0; i < 8; i++)
            send_sample(edge_vals[i]);
        drain();
    endtask

    // Every gain mode and the named corner settings, a few samples each.
    task automatic test_modes_and_corners;
        int m;
        for (m = 0; m < 4; m++)
        begin
            write_reg(REG_MODE, m);
            write_reg(REG_THRESHOLD, (m == 2) ? 15'h7000 : 15'h4000);
            write_reg(REG_ATTACK, 0);
            write_reg(REG_RELEASE, 24'hffffff);
            write_done();
            send_sample({1'b0, {(SB-1){1'b1}}});
            send_sample({1'b1, {(SB-1){1'b0}}});
            send_sample(24'sh000100);
            drain();
        end
        // Zero knee width in soft mode, ratio below one, wet mix beyond one,
        // positive threshold and full makeup gain.
        write_reg(REG_MODE, MODE_SOFT);
        write_reg(REG_KNEE, 0);
        write_reg(REG_RATIO, 100);
        write_reg(REG_WET, 17'h1ffff);
        write_reg(REG_MAKEUP, 13'h1fff);
        write_reg(REG_THRESHOLD, 15'h3fff);
        write_reg(REG_RELEASE, 0);
        write_done();
        send_sample(24'sh400000);
        send_sample(-24'sh000001);
        drain();
        write_reg(REG_RATIO, 13'h1fff);
        write_reg(REG_KNEE, 13'h1fff);
        write_reg(REG_THRESHOLD, 15'h6000);
        write_reg(REG_WET, 0);
        write_reg(REG_MAKEUP, 0);
        write_done();
        send_sample({1'b0, {(SB-1){1'b1}}});
        send_sample(24'sh010000);
        write_done();
        drain();
    endtask

    // Random phases: a fresh configuration, then a run of samples with
    // bursty input and a changing receiver pattern.
    task automatic test_random_phases(input int phases, input int per_phase);
        int p;
        int i;
        bit gaps;
        for (p = 0; p < phases; p++)
        begin
            write_reg(REG_THRESHOLD, pick_reg(32'h4000, 32'h7fff, 32'h7fff));
            write_reg(REG_RATIO, pick_reg(256, 5120, 13'h1fff));
            write_reg(REG_KNEE, pick_reg(0, 6144, 13'h1fff));
            write_reg(REG_MAKEUP, pick_reg(0, 6144, 13'h1fff));
            write_reg(REG_WET, pick_reg(0, 65536, 17'h1ffff));
            write_reg(REG_ATTACK, pick_reg(0, 24'hffffff, 24'hffffff));
            write_reg(REG_RELEASE, pick_reg(15000000, 24'hffffff, 24'hffffff));
            write_reg(REG_MODE, ($urandom_range(0, 7) == 0) ? MODE_BYPASS :
                                $urandom_range(0, 2));
            write_done();
            gaps = 1'b1;
            for (i = 0; i < per_phase; i++)
            begin
                if (i % 40 == 0)
                    gaps = $urandom_range(0, 2) != 0;
                send_sample(pick_sample());
                sender_gap(gaps);
            end
            drain();
        end
    endtask

    // The receiver holds off while samples keep coming, so the block backs
    // up and stalls its input; afterwards the sender waits for everything.
    task automatic test_back_pressure;
        int i;
        hold_cycles = 600;
        for (i = 0; i < 16; i++)
            send_sample(pick_sample());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample_in   = '0;
        mismatches  = 0;
        failures    = 0;
        cycle_count = 0;
        hold_cycles = 0;
        offering    = 1'b0;
        loud_level  = 20;
        thr_q8      = 15'd0;
        ratio_q8    = 13'd1024;
        knee_q8     = 13'd1536;
        makeup_q8   = 13'd0;
        wet_q16     = 17'd65536;
        attack_q24  = 24'd16434000;
        release_q24 = 24'd16774000;
        mode_sel    = MODE_SOFT;
        env_level   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_modes_and_corners();
        test_back_pressure();
        test_random_phases(7, 240);
        test_back_pressure();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
